FILE: rtl/core/ghalloc_pkg.sv
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Shared types and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_AW   = 10;
  localparam int GEN_W     = 16;
  localparam int CNT_W     = 11;

  typedef logic [SLOT_AW-1:0] slot_idx_t;
  typedef logic [GEN_W-1:0]   gen_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam cnt_t SLOT_LIMIT = CNT_W'(MAX_SLOTS);

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DEAD = 2'd2;

  typedef struct packed {
    logic live;
    gen_t gen;
  } slot_entry_t;

  typedef struct packed {
    logic        en;
    slot_idx_t   addr;
    slot_entry_t entry;
  } slot_wr_t;

  typedef struct packed {
    logic      en;
    slot_idx_t addr;
  } slot_rd_t;

  typedef struct packed {
    logic      rd_top;
    logic      push;
    logic      pop;
    slot_idx_t push_idx;
  } stack_cmd_t;

endpackage

FILE: rtl/core/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Allocator of index/generation handles over a slot table and a free stack.
// ----------------------------------------------------------------------------
// in_tuser carries the op (create, destroy, query), in_tdata the handle.
// Each request gives exactly one result on the out channel: out_tuser holds
// the status, out_tdata the handle and the live count after the request.
// One request is worked on at a time. A request passes a lookup state,
// a pop state for a create that reuses a freed slot, then a finish state.
// The free stack top and the slot entry each come from a memory with a
// registered read, and a reused slot needs the stack read before the
// slot read. in_tready is high again in the cycle the result shows up, so
// the block takes no new request before the last one has its result.
// The result sits in an output register; while out_tready is low it holds
// and the block still accepts the next request, whose result then waits
// until the register is taken. Reset clears the stack depth, the count of
// slots handed out and the live count; the memories need no clearing since
// only entries below those counts are ever used.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entity_index[9:0], entity_generation[25:10]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // handle_index[9:0], handle_generation[25:10],
                                  // live_total[36:26]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import ghalloc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_POP, S_FIN} state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  slot_idx_t   idx_r, idx_nxt;
  gen_t        gen_r, gen_nxt;
  cnt_t        hw_r, hw_nxt;
  cnt_t        live_r, live_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  slot_idx_t   res_idx_r, res_idx_nxt;
  gen_t        res_gen_r, res_gen_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  slot_idx_t   out_idx_r, out_idx_nxt;
  gen_t        out_gen_r, out_gen_nxt;
  cnt_t        out_live_r, out_live_nxt;

  slot_rd_t    slot_rd;
  slot_wr_t    slot_wr;
  slot_entry_t slot_q;
  stack_cmd_t  stack_cmd;
  slot_idx_t   stack_top;
  cnt_t        stack_depth;

  logic        in_fire;
  logic        alive;

  ghalloc_slot_table u_slot_table (
    .clk       (clk),
    .rd_i      (slot_rd),
    .wr_i      (slot_wr),
    .rd_data_o (slot_q)
  );

  ghalloc_free_stack u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (stack_cmd),
    .top_o   (stack_top),
    .depth_o (stack_depth)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign alive = ({1'b0, idx_r} < hw_r) && slot_q.live && (slot_q.gen == gen_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    gen_nxt        = gen_r;
    hw_nxt         = hw_r;
    live_nxt       = live_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_gen_nxt    = res_gen_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_gen_nxt    = out_gen_r;
    out_live_nxt   = out_live_r;

    slot_rd   = '{en: 1'b0, addr: in_tdata[SLOT_AW-1:0]};
    slot_wr   = '0;
    stack_cmd = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt           = in_tuser;
          idx_nxt          = in_tdata[SLOT_AW-1:0];
          gen_nxt          = in_tdata[SLOT_AW+GEN_W-1:SLOT_AW];
          slot_rd.en       = 1'b1;
          stack_cmd.rd_top = 1'b1;
          state_nxt        = S_LOOK;
        end
      end
      S_LOOK: begin
        res_status_nxt = ST_OK;
        res_idx_nxt    = idx_r;
        res_gen_nxt    = gen_r;
        state_nxt      = S_FIN;
        case (op_r)
          OP_CREATE: begin
            if (stack_depth != '0) begin
              stack_cmd.pop = 1'b1;
              slot_rd.en    = 1'b1;
              slot_rd.addr  = stack_top;
              res_idx_nxt   = stack_top;
              state_nxt     = S_POP;
            end else if (hw_r < SLOT_LIMIT) begin
              slot_wr     = '{en: 1'b1, addr: hw_r[SLOT_AW-1:0],
                              entry: '{live: 1'b1, gen: '0}};
              res_idx_nxt = hw_r[SLOT_AW-1:0];
              res_gen_nxt = '0;
              hw_nxt      = hw_r + cnt_t'(1);
              live_nxt    = live_r + cnt_t'(1);
            end else begin
              res_status_nxt = ST_FULL;
            end
          end
          OP_DESTROY: begin
            if (alive && (stack_depth < SLOT_LIMIT)) begin
              slot_wr = '{en: 1'b1, addr: idx_r,
                          entry: '{live: 1'b0, gen: slot_q.gen + gen_t'(1)}};
              stack_cmd.push     = 1'b1;
              stack_cmd.push_idx = idx_r;
              if (live_r != '0) begin
                live_nxt = live_r - cnt_t'(1);
              end
            end else begin
              res_status_nxt = ST_DEAD;
            end
          end
          default: begin
            res_status_nxt = alive ? ST_OK : ST_DEAD;
          end
        endcase
      end
      S_POP: begin
        slot_wr     = '{en: 1'b1, addr: res_idx_r,
                        entry: '{live: 1'b1, gen: slot_q.gen}};
        res_gen_nxt = slot_q.gen;
        live_nxt    = live_r + cnt_t'(1);
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_gen_nxt    = res_gen_r;
          out_live_nxt   = live_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hw_r        <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hw_r        <= hw_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    gen_r        <= gen_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_gen_r    <= res_gen_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_gen_r    <= out_gen_nxt;
    out_live_r   <= out_live_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_live_r, out_gen_r, out_idx_r};

endmodule

FILE: rtl/core/ghalloc_slot_table.sv
// ----------------------------------------------------------------------------
// ghalloc_slot_table
// Per-slot live mark and generation, one write and one registered read port.
// ----------------------------------------------------------------------------
module ghalloc_slot_table (
  input  logic                      clk,
  input  ghalloc_pkg::slot_rd_t     rd_i,
  input  ghalloc_pkg::slot_wr_t     wr_i,
  output ghalloc_pkg::slot_entry_t  rd_data_o
);
  import ghalloc_pkg::*;

  slot_entry_t mem [MAX_SLOTS];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_i.en) begin
      rd_data_r <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_r;

endmodule

FILE: rtl/core/ghalloc_free_stack.sv
// ----------------------------------------------------------------------------
// ghalloc_free_stack
// LIFO of freed slot indexes with its depth counter and registered top read.
// ----------------------------------------------------------------------------
module ghalloc_free_stack (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ghalloc_pkg::stack_cmd_t  cmd_i,
  output ghalloc_pkg::slot_idx_t   top_o,
  output ghalloc_pkg::cnt_t        depth_o
);
  import ghalloc_pkg::*;

  slot_idx_t mem [MAX_SLOTS];
  slot_idx_t top_r;
  cnt_t      depth_r;
  cnt_t      depth_nxt;
  cnt_t      top_ptr;

  assign top_ptr = depth_r - cnt_t'(1);

  always_comb begin
    depth_nxt = depth_r;
    if (cmd_i.push) begin
      depth_nxt = depth_r + cnt_t'(1);
    end else if (cmd_i.pop) begin
      depth_nxt = top_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.push) begin
      mem[depth_r[SLOT_AW-1:0]] <= cmd_i.push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd_top) begin
      top_r <= mem[top_ptr[SLOT_AW-1:0]];
    end
  end

  assign top_o   = top_r;
  assign depth_o = depth_r;

endmodule

FILE: rtl/core/ghalloc_checker.sv
// ----------------------------------------------------------------------------
// ghalloc_checker
// Port-level checks of the generational handle allocator, bound to the top.
// ----------------------------------------------------------------------------
module ghalloc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import ghalloc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  // full only when every slot is live
  a_full_all_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (out_tdata[36:26] == SLOT_LIMIT))
    else $error("full reported with free slots");

  // live count bounded
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:26] <= SLOT_LIMIT) &&
      (out_tuser == ST_OK || out_tuser == ST_FULL || out_tuser == ST_DEAD))
    else $error("live count or status out of range");

endmodule

bind generational_handle_allocator ghalloc_checker u_ghalloc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
